FILE: rtl/button_debounce_long_press_core_defines.svh
// Assertion macros shared by the debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdlp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdlp assertion failed");

`endif

FILE: rtl/bdlp_pkg.sv
// Types and constants of the button debounce and long-press block.
package bdlp_pkg;

    localparam int PHASE_W  = 3;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NOW_W    = 32;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE           = 3'd0,
        PH_PRESS_BOUNCE   = 3'd1,
        PH_HELD           = 3'd2,
        PH_RELEASE_BOUNCE = 3'd3,
        PH_RELEASED       = 3'd4,
        PH_DETECTED       = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS   = 2'd0,
        CFG_LONG_PRESS_MS = 2'd1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

endpackage

FILE: rtl/bdlp_in_if.sv
// Poll channel: button level and millisecond timestamp.
interface bdlp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         button_level;
    logic [bdlp_pkg::NOW_W-1:0]   now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

FILE: rtl/bdlp_out_if.sv
// Result channel: detect flag and phase after each poll.
interface bdlp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         press_detected;
    logic [bdlp_pkg::PHASE_W-1:0] phase;

    modport source (output valid, output press_detected, output phase, input ready);
    modport sink   (input valid, input press_detected, input phase, output ready);
endinterface

FILE: rtl/button_debounce_long_press_core.sv
// Button debouncer with long-press detection: top level.
//
// Use: each word on i_in is one poll of an active-low button (button_level,
// 0 = pressed) with a wrapping millisecond timestamp (now_ms). Every poll
// yields exactly one word on o_out: the phase after the poll and a flag that
// is high for the one poll that ends in the detected phase.
// Configuration: i_cfg_we with i_cfg_idx 0 writes debounce_ms, index 1 writes
// long_press_ms; other indexes are dropped. Write only while no poll is in
// flight.
// Path: an accepted poll is held in the input register and moves into the
// output register once that register is empty or its word is taken.
// Throughput: one poll per cycle while o_out.ready is high; the phase update
// is a single subtract-and-compare pass between the input and output registers.
// Timestamps are kept at TIME_BITS bits and differences wrap at that width.
// Reset: synchronous, active low; the phase returns to idle, timestamps
// clear, debounce_ms to 50 and long_press_ms to 1000, both registers empty.
// Stall: while o_out.ready is low the result holds; one more poll is taken
// into the input register and then i_in.ready drops until the output drains.
module button_debounce_long_press_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bdlp_in_if.sink                        i_in,
    bdlp_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bdlp_pkg::CFG_W-1:0]     i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg                 w_cfg;
    t_phase               w_phase;
    logic                 w_detected;
    logic                 w_advance;
    logic [TIME_BITS-1:0] w_now;

    logic                 r_in_valid;
    logic                 r_in_level;
    logic [NOW_W-1:0]     r_in_now;
    logic                 r_out_valid;
    logic                 r_out_detected;
    logic [PHASE_W-1:0]   r_out_phase;

    bdlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_now = TIME_BITS'(r_in_now);

    bdlp_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_level    (r_in_level),
        .i_now      (w_now),
        .i_cfg      (w_cfg),
        .o_phase    (w_phase),
        .o_detected (w_detected)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_level <= i_in.button_level;
            r_in_now   <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_detected <= w_detected;
            r_out_phase    <= w_phase;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.press_detected = r_out_detected;
    assign o_out.phase          = r_out_phase;

endmodule

FILE: rtl/bdlp_cfg.sv
// Configuration registers of the debounce block.
module bdlp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bdlp_pkg::CFG_W-1:0]    i_cfg_data,
    output bdlp_pkg::t_cfg                o_cfg
);
    import bdlp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
            r_cfg.long_press_ms <= LONG_PRESS_MS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_cfg.long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/bdlp_fsm.sv
// Phase machine with bounce and press timestamps.
`include "button_debounce_long_press_core_defines.svh"
module bdlp_fsm #(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_level,
    input  logic [TIME_BITS-1:0]  i_now,
    input  bdlp_pkg::t_cfg        i_cfg,
    output bdlp_pkg::t_phase      o_phase,
    output logic                  o_detected
);
    import bdlp_pkg::*;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [TIME_BITS-1:0] r_bounce_start;
    logic [TIME_BITS-1:0] n_bounce_start;
    logic [TIME_BITS-1:0] r_press_start;
    logic [TIME_BITS-1:0] n_press_start;
    logic [TIME_BITS-1:0] w_bounce_elapsed;
    logic [TIME_BITS-1:0] w_hold_elapsed;
    logic                 w_db_done;
    logic                 w_hold_done;

    assign w_bounce_elapsed = i_now - r_bounce_start;
    assign w_hold_elapsed   = i_now - r_press_start;
    assign w_db_done        = w_bounce_elapsed >= TIME_BITS'(i_cfg.debounce_ms);
    assign w_hold_done      = w_hold_elapsed >= TIME_BITS'(i_cfg.long_press_ms);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_PRESS_BOUNCE: begin
                if (!i_level && w_db_done) n_phase = PH_HELD;
            end
            PH_HELD: begin
                if (i_level) n_phase = PH_RELEASE_BOUNCE;
            end
            PH_RELEASE_BOUNCE: begin
                if (i_level && w_db_done) n_phase = PH_RELEASED;
            end
            PH_RELEASED: begin
                if (i_level) n_phase = w_hold_done ? PH_DETECTED : PH_IDLE;
            end
            PH_DETECTED: n_phase = PH_IDLE;
            default: begin
                n_phase = i_level ? PH_IDLE : PH_PRESS_BOUNCE;
            end
        endcase
    end

    always_comb begin
        n_bounce_start = r_bounce_start;
        n_press_start  = r_press_start;
        unique case (r_phase)
            PH_PRESS_BOUNCE: begin
                if (i_level) n_bounce_start = i_now;
            end
            PH_HELD: begin
                if (i_level) n_bounce_start = i_now;
            end
            PH_RELEASE_BOUNCE: begin
                if (!i_level) n_bounce_start = i_now;
            end
            PH_RELEASED, PH_DETECTED: ;
            default: begin
                if (!i_level) begin
                    n_bounce_start = i_now;
                    n_press_start  = i_now;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bounce_start <= '0;
            r_press_start  <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bounce_start <= n_bounce_start;
            r_press_start  <= n_press_start;
        end
    end

    assign o_phase    = n_phase;
    assign o_detected = (n_phase == PH_DETECTED);

    `BDLP_ASSERT_NXT(a_detect_one_poll, i_clk, i_rst_n, i_step && (r_phase == PH_DETECTED), r_phase == PH_IDLE)
    `BDLP_ASSERT_NXT(a_press_capture, i_clk, i_rst_n, i_step && (r_phase == PH_IDLE) && !i_level, (r_phase == PH_PRESS_BOUNCE) && (r_press_start == $past(i_now)))
    `BDLP_ASSERT_NXT(a_released_waits, i_clk, i_rst_n, i_step && (r_phase == PH_RELEASED) && !i_level, r_phase == PH_RELEASED)
    `BDLP_ASSERT_IMP(a_detect_from_released, i_clk, i_rst_n, o_detected, r_phase == PH_RELEASED)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the button debounce and long-press core.
module testbench;
    import bdlp_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 800_000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_POLLS  = 100;
    localparam int unsigned N_ROWS       = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef struct packed {
        logic   detected;
        t_phase phase;
    } t_poll_result;

    typedef struct packed {
        logic             level;
        logic [NOW_W-1:0] now;
        bit               pinned;
        logic             detected;
        t_phase           phase;
    } t_poll_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bdlp_in_if  poll_if ();
    bdlp_out_if res_if ();

    button_debounce_long_press_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (poll_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    t_phase           mdl_phase     = PH_IDLE;
    logic [NOW_W-1:0] mdl_bounce_t  = '0;
    logic [NOW_W-1:0] mdl_press_t   = '0;
    logic [CFG_W-1:0] mdl_debounce  = DEBOUNCE_MS_RST;
    logic [CFG_W-1:0] mdl_long      = LONG_PRESS_MS_RST;

    t_poll_result     pending_results[$];
    t_poll_result     in_pin;
    bit               in_pinned;
    int unsigned      fail_cnt = 0;
    int unsigned      cycle_cnt = 0;
    int unsigned      phase_polls;
    bit               tx_quiet;
    bit               rx_quiet = 1'b0;
    bit               long_hold_req;
    int unsigned      cur_debounce;
    int unsigned      cur_long;
    logic [NOW_W-1:0] wall_ms;
    t_poll_row        directed_rows [N_ROWS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_poll_result track_button(input logic level,
                                                  input logic [NOW_W-1:0] now);
        t_poll_result     r;
        logic [NOW_W-1:0] since_bounce;
        logic [NOW_W-1:0] since_press;
        since_bounce = now - mdl_bounce_t;
        since_press  = now - mdl_press_t;
        case (mdl_phase)
            PH_PRESS_BOUNCE: begin
                if (level)
                    mdl_bounce_t = now;
                else if (since_bounce >= NOW_W'(mdl_debounce))
                    mdl_phase = PH_HELD;
            end
            PH_HELD: begin
                if (level) begin
                    mdl_bounce_t = now;
                    mdl_phase    = PH_RELEASE_BOUNCE;
                end
            end
            PH_RELEASE_BOUNCE: begin
                if (!level)
                    mdl_bounce_t = now;
                else if (since_bounce >= NOW_W'(mdl_debounce))
                    mdl_phase = PH_RELEASED;
            end
            PH_RELEASED: begin
                if (level)
                    mdl_phase = (since_press >= NOW_W'(mdl_long)) ? PH_DETECTED : PH_IDLE;
            end
            PH_DETECTED: begin
                mdl_phase = PH_IDLE;
            end
            default: begin
                mdl_phase = PH_IDLE;
                if (!level) begin
                    mdl_bounce_t = now;
                    mdl_press_t  = now;
                    mdl_phase    = PH_PRESS_BOUNCE;
                end
            end
        endcase
        r.detected = (mdl_phase == PH_DETECTED);
        r.phase    = mdl_phase;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_poll_result want;
        t_poll_result got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.detected = res_if.press_detected;
                got.phase    = t_phase'(res_if.phase);
                if (pending_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected word: detected=%0d phase=%0d",
                                 got.detected, got.phase);
                end else begin
                    want = pending_results.pop_front();
                    if (got.detected !== want.detected || got.phase !== want.phase) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch: expected detected=%0d phase=%0d, ",
                                      "got detected=%0d phase=%0d"},
                                     want.detected, want.phase, got.detected, got.phase);
                    end
                end
            end
            if (poll_if.valid && poll_if.ready) begin
                want = track_button(poll_if.button_level, poll_if.now_ms);
                if (in_pinned)
                    want = in_pin;
                pending_results.push_back(want);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEBOUNCE_MS)
                    mdl_debounce = i_cfg_data;
                else if (i_cfg_idx == CFG_LONG_PRESS_MS)
                    mdl_long = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        stall_left   = 0;
        run_left     = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                rx_quiet = !rx_quiet;
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    if (!rx_quiet)
                        stall_left = pick_gap();
                    run_left = $urandom_range(0, 8);
                end
            end
        end
    end

    task automatic send_poll(input logic level, input logic [NOW_W-1:0] now,
                             input bit pinned, input t_poll_result pin);
        int unsigned gap;
        @(negedge i_clk);
        poll_if.valid        <= 1'b1;
        poll_if.button_level <= level;
        poll_if.now_ms       <= now;
        in_pinned            <= pinned;
        in_pin               <= pin;
        do @(posedge i_clk); while (!poll_if.ready);
        phase_polls++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            poll_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic poll(input logic level);
        send_poll(level, wall_ms, 1'b0, '0);
    endtask

    task automatic settle();
        @(negedge i_clk);
        poll_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic press_episode();
        int unsigned      hold_ms;
        logic [NOW_W-1:0] t_first;
        logic [NOW_W-1:0] t_mark;
        repeat ($urandom_range(0, 2)) begin
            wall_ms += $urandom_range(1, cur_debounce + 1);
            poll(1'b1);
        end
        wall_ms += $urandom_range(1, 50);
        t_first = wall_ms;
        poll(1'b0);
        repeat ($urandom_range(0, 3)) begin
            wall_ms += $urandom_range(0, cur_debounce / 4 + 1);
            poll(1'b1);
            wall_ms += $urandom_range(0, cur_debounce / 4 + 1);
            poll(1'b0);
        end
        t_mark = wall_ms;
        while (NOW_W'(wall_ms - t_mark) < cur_debounce) begin
            wall_ms += $urandom_range(1, cur_debounce / 3 + 1);
            poll(1'b0);
        end
        hold_ms = $urandom_range(0, 2 * cur_long + 20);
        while (NOW_W'(wall_ms - t_first) < hold_ms) begin
            wall_ms += $urandom_range(1, hold_ms / 3 + 1);
            poll(1'b0);
        end
        wall_ms += $urandom_range(1, 20);
        poll(1'b1);
        repeat ($urandom_range(0, 3)) begin
            wall_ms += $urandom_range(0, cur_debounce / 4 + 1);
            poll(1'b0);
            wall_ms += $urandom_range(0, cur_debounce / 4 + 1);
            poll(1'b1);
        end
        t_mark = wall_ms;
        while (NOW_W'(wall_ms - t_mark) < cur_debounce) begin
            wall_ms += $urandom_range(1, cur_debounce / 3 + 1);
            poll(1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            wall_ms += $urandom_range(0, 20);
            poll(1'b0);
        end
        wall_ms += $urandom_range(0, cur_long / 2 + 1);
        poll(1'b1);
        wall_ms += $urandom_range(0, 20);
        poll(1'($urandom_range(0, 1)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
                wall_ms = $urandom();
            else
                wall_ms += $urandom_range(0, cur_debounce + 1);
            poll(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int unsigned dbn_set [9];
        int unsigned long_set [9];
        t_poll_result pin;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_DEBOUNCE_MS;
        i_cfg_data           = '0;
        poll_if.valid        = 1'b0;
        poll_if.button_level = 1'b1;
        poll_if.now_ms       = '0;
        in_pinned            = 1'b0;
        in_pin               = '0;
        tx_quiet             = 1'b0;
        long_hold_req        = 1'b0;
        cur_debounce         = 32'(DEBOUNCE_MS_RST);
        cur_long             = 32'(LONG_PRESS_MS_RST);

        directed_rows = '{
            '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, PH_IDLE},
            '{1'b0, 32'd100,       1'b1, 1'b0, PH_PRESS_BOUNCE},
            '{1'b1, 32'd120,       1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd160,       1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd170,       1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd500,       1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd1050,      1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd1060,      1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd1110,      1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd1200,      1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd1300,      1'b1, 1'b1, PH_DETECTED},
            '{1'b0, 32'd1310,      1'b1, 1'b0, PH_IDLE},
            '{1'b0, 32'd2000,      1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'd2050,      1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd2100,      1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd2150,      1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'd2999,      1'b1, 1'b0, PH_IDLE},
            '{1'b0, 32'hFFFF_FFE0, 1'b0, 1'b0, PH_IDLE},
            '{1'b0, 32'h0000_0012, 1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'h0000_0020, 1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'h0000_0052, 1'b0, 1'b0, PH_IDLE},
            '{1'b1, 32'h0000_03C8, 1'b1, 1'b1, PH_DETECTED},
            '{1'b0, 32'h0000_03D0, 1'b1, 1'b0, PH_IDLE}
        };
        dbn_set  = '{50, 0, 65535, 0, 65535, 1, 0, 0, 0};
        long_set = '{1000, 0, 65535, 65535, 0, 1, 0, 0, 0};
        for (int k = 6; k < 9; k++) begin
            dbn_set[k]  = (k == 8) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
            long_set[k] = (k == 8) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            pin.detected = directed_rows[r].detected;
            pin.phase    = directed_rows[r].phase;
            send_poll(directed_rows[r].level, directed_rows[r].now,
                      directed_rows[r].pinned, pin);
        end
        settle();

        for (int p = 0; p < 9; p++) begin
            cur_debounce = dbn_set[p];
            cur_long     = long_set[p];
            write_reg(CFG_DEBOUNCE_MS, CFG_W'(cur_debounce));
            write_reg(CFG_LONG_PRESS_MS, CFG_W'(cur_long));
            if (p == 0) begin
                write_reg(CFG_IDX_SPARE_LO, CFG_W'($urandom()));
                write_reg(CFG_IDX_SPARE_HI, CFG_W'($urandom()));
                long_hold_req = 1'b1;
            end
            tx_quiet    = ($urandom_range(0, 3) == 0);
            wall_ms     = $urandom();
            phase_polls = 0;
            while (phase_polls < PHASE_POLLS) begin
                if ($urandom_range(0, 99) < 15)
                    noise_burst();
                else
                    press_episode();
            end
            settle();
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
